FILE: hw/rtl/spc_pkg.sv
package spc_pkg;

	// Width of the step period and tick counter
	localparam int PERIOD_BITS_DEF = 16;
	localparam logic [31:0] PERIOD_RESET = 32'd5000;

	// Entries in the queue between parser and executor
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] FORCED_BYTE = 8'hFF;

	// Escape byte codes
	localparam logic [7:0] ESC_LOW = 8'h01;
	localparam logic [7:0] ESC_HIGH = 8'h02;
	localparam logic [7:0] ESC_BOTH = 8'h03;

	// Packet command codes
	localparam logic [7:0] CMD_RUN_FWD = 8'h02;
	localparam logic [7:0] CMD_RUN_REV = 8'h03;
	localparam logic [7:0] CMD_STEP_FWD = 8'h04;
	localparam logic [7:0] CMD_STEP_REV = 8'h05;

	typedef enum logic [2:0] {
		PARSE_HUNT,
		PARSE_CMD,
		PARSE_HIGH,
		PARSE_LOW,
		PARSE_ESC
	} parse_pos_t;

	typedef enum logic [2:0] {
		OP_BYTE,
		OP_TICK,
		OP_SET_FWD,
		OP_SET_REV,
		OP_STEP_FWD,
		OP_STEP_REV,
		OP_PACKET_OTHER
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [15:0] value;
	} op_t;

	// Half-step coil sequence
	function automatic logic [3:0] coil_lookup(input logic [2:0] idx);
		logic [3:0] pat;
		case (idx)
			3'd0: pat = 4'h8;
			3'd1: pat = 4'hC;
			3'd2: pat = 4'h4;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h2;
			3'd5: pat = 4'h3;
			3'd6: pat = 4'h1;
			3'd7: pat = 4'h9;
			default: pat = 4'h8;
		endcase
		return pat;
	endfunction

endpackage

FILE: hw/rtl/spc_item_if.sv
interface spc_item_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

FILE: hw/rtl/spc_result_if.sv
interface spc_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] coil_pattern;
	logic [2:0] phase;
	logic       packet_done;
	logic       stepped;

	modport source (output valid, output coil_pattern, output phase, output packet_done,
		output stepped, input ready);
	modport sink (input valid, input coil_pattern, input phase, input packet_done,
		input stepped, output ready);
endinterface

FILE: hw/rtl/stepper_packet_controller.sv
// Half-step stepper sequencer with a serial packet parser. Each input transaction is
// either a received byte (cmd 0) or a timing tick (cmd 1) and yields exactly one result:
// the coil pattern and phase after the item, plus flags for a completed packet and for a
// phase move. One item is accepted per clock. An accepted item is written into the queue
// and then moves into the output register, from which its result is presented. The
// parser front end feeds a two-entry queue, and the executor back end pops from that queue
// whenever its output register is empty or being taken, so input stalls only when the
// result side holds off long enough to fill queue and output register.
module stepper_packet_controller #(
	parameter int PERIOD_BITS = spc_pkg::PERIOD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spc_item_if.sink      item,
	spc_result_if.source  result
);
	import spc_pkg::*;

	logic f_valid;
	logic f_ready;
	op_t  f_op;
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	spc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.op_valid (f_valid),
		.op_ready (f_ready),
		.op       (f_op)
	);

	spc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_op     (b_op)
	);

	spc_back #(
		.PERIOD_BITS (PERIOD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (b_valid),
		.op_ready (b_ready),
		.op       (b_op),
		.result   (result)
	);

endmodule

FILE: hw/rtl/spc_front.sv
module spc_front (
	input  logic            clk,
	input  logic            arst_n,
	spc_item_if.sink        item,
	output logic            op_valid,
	input  logic            op_ready,
	output spc_pkg::op_t    op
);
	import spc_pkg::*;

	parse_pos_t state_q, state_next;
	logic [7:0] command_q;
	logic [7:0] high_q;
	logic [7:0] low_q;
	logic       take;
	logic [7:0] hi_sel;
	logic [7:0] lo_sel;

	assign item.ready = op_ready;
	assign op_valid = item.valid;
	assign take = item.valid && op_ready;

	always_comb begin
		state_next = state_q;
		if (!item.cmd) begin
			case (state_q)
				PARSE_HUNT: if (item.rx_byte == START_BYTE) state_next = PARSE_CMD;
				PARSE_CMD:  state_next = PARSE_HIGH;
				PARSE_HIGH: state_next = PARSE_LOW;
				PARSE_LOW:  state_next = PARSE_ESC;
				PARSE_ESC:  state_next = PARSE_HUNT;
				default:    state_next = PARSE_HUNT;
			endcase
		end
	end

	always_comb begin
		hi_sel = high_q;
		lo_sel = low_q;
		if (item.rx_byte == ESC_BOTH) begin
			hi_sel = FORCED_BYTE;
			lo_sel = FORCED_BYTE;
		end else if (item.rx_byte == ESC_HIGH) begin
			hi_sel = FORCED_BYTE;
		end else if (item.rx_byte == ESC_LOW) begin
			lo_sel = FORCED_BYTE;
		end
		op.value = {hi_sel, lo_sel};
		if (item.cmd) begin
			op.kind = OP_TICK;
		end else if (state_q == PARSE_ESC) begin
			case (command_q)
				CMD_RUN_FWD:  op.kind = OP_SET_FWD;
				CMD_RUN_REV:  op.kind = OP_SET_REV;
				CMD_STEP_FWD: op.kind = OP_STEP_FWD;
				CMD_STEP_REV: op.kind = OP_STEP_REV;
				default:      op.kind = OP_PACKET_OTHER;
			endcase
		end else begin
			op.kind = OP_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_HUNT;
		end else if (take) begin
			state_q <= state_next;
		end
	end

	// Latch packet fields as they arrive
	always_ff @(posedge clk) begin
		if (take && !item.cmd) begin
			if (state_q == PARSE_CMD) command_q <= item.rx_byte;
			if (state_q == PARSE_HIGH) high_q <= item.rx_byte;
			if (state_q == PARSE_LOW) low_q <= item.rx_byte;
		end
	end

endmodule

FILE: hw/rtl/spc_queue.sv
module spc_queue #(
	parameter int DEPTH = spc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  spc_pkg::op_t    push_op,
	output logic            pop_valid,
	input  logic            pop_ready,
	output spc_pkg::op_t    pop_op
);
	import spc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = count_q < CW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_op = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: hw/rtl/spc_back.sv
module spc_back #(
	parameter int PERIOD_BITS = spc_pkg::PERIOD_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_ready,
	input  spc_pkg::op_t    op,
	spc_result_if.source    result
);
	import spc_pkg::*;

	logic [PERIOD_BITS-1:0]    period_q, period_next;
	logic [PERIOD_BITS-1:0]    count_q, count_next;
	logic [PERIOD_BITS+15:0]   value_ext;
	logic                      fwd_q, fwd_next;
	logic [2:0]                phase_q, phase_next;
	logic                      done;
	logic                      stepped;
	logic                      take;
	logic                      out_valid_q;
	logic [3:0]                coil_q;
	logic                      done_q;
	logic                      stepped_q;

	// Fit the 16-bit packet value to the period width
	assign value_ext = {{PERIOD_BITS{1'b0}}, op.value};

	assign op_ready = !out_valid_q || result.ready;
	assign take = op_valid && op_ready;

	always_comb begin
		period_next = period_q;
		count_next = count_q;
		fwd_next = fwd_q;
		phase_next = phase_q;
		done = 1'b1;
		stepped = 1'b0;
		case (op.kind)
			OP_BYTE: begin
				done = 1'b0;
			end
			OP_TICK: begin
				done = 1'b0;
				if (period_q != '0) begin
					if (count_q >= period_q) begin
						phase_next = fwd_q ? phase_q + 3'd1 : phase_q - 3'd1;
						stepped = 1'b1;
						count_next = '0;
					end else begin
						count_next = count_q + 1'b1;
					end
				end
			end
			OP_SET_FWD: begin
				fwd_next = 1'b1;
				period_next = value_ext[PERIOD_BITS-1:0];
				count_next = '0;
			end
			OP_SET_REV: begin
				fwd_next = 1'b0;
				period_next = value_ext[PERIOD_BITS-1:0];
				count_next = '0;
			end
			OP_STEP_FWD: begin
				phase_next = phase_q + 3'd1;
				stepped = 1'b1;
				period_next = '0;
				count_next = '0;
			end
			OP_STEP_REV: begin
				phase_next = phase_q - 3'd1;
				stepped = 1'b1;
				period_next = '0;
				count_next = '0;
			end
			default: begin
				count_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET[PERIOD_BITS-1:0];
			count_q <= '0;
			fwd_q <= 1'b1;
			phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				period_q <= period_next;
				count_q <= count_next;
				fwd_q <= fwd_next;
				phase_q <= phase_next;
			end
			if (op_ready) out_valid_q <= op_valid;
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk) begin
		if (take) begin
			coil_q <= coil_lookup(phase_next);
			done_q <= done;
			stepped_q <= stepped;
		end
	end

	assign result.valid = out_valid_q;
	assign result.coil_pattern = coil_q;
	assign result.phase = phase_q;
	assign result.packet_done = done_q;
	assign result.stepped = stepped_q;

endmodule
